FILE: rtl/core/two_point_calibration_fit_macros.svh
// Assertion macros for the two-point calibration fit block.
`ifndef TWO_POINT_CALIBRATION_FIT_MACROS_SVH
`define TWO_POINT_CALIBRATION_FIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TPCF_ASSERT_IMPLY(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define TPCF_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/core/tpcf_pkg.sv
// Types and constants for the two-point calibration fit block.
package tpcf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 16;
   localparam int QUO_W     = IN_W + FRAC_BITS;
   localparam int PROD_W    = IN_W + QUO_W;
   localparam int SLOPE_W   = 33;
   localparam int ICPT_W    = 49;
   localparam int REQ_W     = 4 * IN_W;
   localparam int RSP_W     = 88;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_ORDER    = 2'd3
   } status_type;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_REFERENCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_CONVERTER = 1'd1;

   localparam logic [IN_W-1:0] MAX_REFERENCE_RESET = 16'd1000;
   localparam logic [IN_W-1:0] MAX_CONVERTER_RESET = 16'd4095;

endpackage

FILE: rtl/core/two_point_calibration_fit.sv
// Two-point linear calibration fit. Each request carries two reference readings (y) and two
// converter readings (x); the block returns a status code, slope = (y2-y1)/(x2-x1) in signed
// fixed point with FRAC_BITS fraction bits (truncated toward zero) and intercept =
// y1 - x1*slope, exact from that slope. Status: ok, divide by zero (equal converter readings,
// fit zeroed, fit_written low), reading above limit, points out of order; divide by zero wins
// over out of order, which wins over above limit. One request is accepted per cycle while the
// output is not stalled. The request is registered at the accepting edge, then passes
// 16 + FRAC_BITS divider stages that resolve one quotient bit each, a multiply stage and the
// intercept/output stage, after which rsp_tvalid rises. A stalled output stalls the whole
// pipeline. Limit registers may be written at any time through the csr port.
module two_point_calibration_fit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // ref_second [15:0], ref_first [31:16], conv_second [47:32], conv_first [63:48]
   input  logic [tpcf_pkg::REQ_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status [1:0], fit_written [2], slope [35:3], intercept [84:36], zero pad [87:85]
   output logic [tpcf_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tpcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tpcf_pkg::IN_W-1:0]       csr_data
);
   import tpcf_pkg::*;

   // ---------------- limit registers ----------------
   logic [IN_W-1:0] max_ref_ff;
   logic [IN_W-1:0] max_conv_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ref_ff  <= MAX_REFERENCE_RESET;
         max_conv_ff <= MAX_CONVERTER_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MAX_REFERENCE: max_ref_ff  <= csr_data;
            REG_MAX_CONVERTER: max_conv_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic rsp_valid_ff;
   logic advance;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // ---------------- entry: checks and magnitudes ----------------
   logic [IN_W-1:0] y2, y1, x2, x1;
   logic            dy_neg, dx_neg;
   logic [IN_W-1:0] dy_mag, dx_mag;
   status_type      status_in;

   assign y2 = req_tdata[IN_W-1:0];
   assign y1 = req_tdata[2*IN_W-1:IN_W];
   assign x2 = req_tdata[3*IN_W-1:2*IN_W];
   assign x1 = req_tdata[4*IN_W-1:3*IN_W];

   always_comb begin
      dy_neg = y1 > y2;
      dx_neg = x1 > x2;
      dy_mag = dy_neg ? (y1 - y2) : (y2 - y1);
      dx_mag = dx_neg ? (x1 - x2) : (x2 - x1);
      status_in = STATUS_OK;
      if (y2 > max_ref_ff)  status_in = STATUS_RANGE;
      if (x2 > max_conv_ff) status_in = STATUS_RANGE;
      if (dy_neg || dx_neg) status_in = STATUS_ORDER;
      if (x1 == x2)         status_in = STATUS_DIV_ZERO;
   end

   // ---------------- divider: one quotient bit per stage ----------------
   // Stage 0 holds the request as it enters; stage s+1 has resolved s+1 quotient bits.
   logic             div_valid_ff [0:QUO_W];
   logic [IN_W-1:0]  div_rem_ff   [0:QUO_W];
   logic [QUO_W-1:0] div_dvd_ff   [0:QUO_W];
   logic [QUO_W-1:0] div_quo_ff   [0:QUO_W];
   logic [IN_W-1:0]  div_dx_ff    [0:QUO_W];
   logic [IN_W-1:0]  div_x1_ff    [0:QUO_W];
   logic [IN_W-1:0]  div_y1_ff    [0:QUO_W];
   logic             div_neg_ff   [0:QUO_W];
   status_type       div_status_ff[0:QUO_W];

   logic [IN_W-1:0]  div_rem_in [0:QUO_W-1];
   logic             div_bit_in [0:QUO_W-1];

   always_comb begin
      for (int s = 0; s < QUO_W; s++) begin
         logic [IN_W:0] trial;
         logic [IN_W:0] diff;
         trial = {div_rem_ff[s], div_dvd_ff[s][QUO_W-1]};
         diff  = trial - {1'b0, div_dx_ff[s]};
         div_bit_in[s] = !diff[IN_W];
         div_rem_in[s] = diff[IN_W] ? trial[IN_W-1:0] : diff[IN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QUO_W; s++) div_valid_ff[s] <= 1'b0;
      end else if (advance) begin
         div_valid_ff[0] <= req_tvalid;
         for (int s = 0; s < QUO_W; s++) div_valid_ff[s+1] <= div_valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_rem_ff[0]    <= '0;
         div_dvd_ff[0]    <= {dy_mag, {FRAC_BITS{1'b0}}};
         div_quo_ff[0]    <= '0;
         div_dx_ff[0]     <= dx_mag;
         div_x1_ff[0]     <= x1;
         div_y1_ff[0]     <= y1;
         div_neg_ff[0]    <= dy_neg ^ dx_neg;
         div_status_ff[0] <= status_in;
         for (int s = 0; s < QUO_W; s++) begin
            div_rem_ff[s+1]    <= div_rem_in[s];
            div_dvd_ff[s+1]    <= {div_dvd_ff[s][QUO_W-2:0], 1'b0};
            div_quo_ff[s+1]    <= {div_quo_ff[s][QUO_W-2:0], div_bit_in[s]};
            div_dx_ff[s+1]     <= div_dx_ff[s];
            div_x1_ff[s+1]     <= div_x1_ff[s];
            div_y1_ff[s+1]     <= div_y1_ff[s];
            div_neg_ff[s+1]    <= div_neg_ff[s];
            div_status_ff[s+1] <= div_status_ff[s];
         end
      end
   end

   // ---------------- multiply: x1 * |slope| ----------------
   logic              mul_valid_ff;
   logic [PROD_W-1:0] mul_prod_ff;
   logic [QUO_W-1:0]  mul_quo_ff;
   logic [IN_W-1:0]   mul_y1_ff;
   logic              mul_neg_ff;
   status_type        mul_status_ff;
   logic [PROD_W-1:0] mul_prod_in;

   assign mul_prod_in = {{QUO_W{1'b0}}, div_x1_ff[QUO_W]} * {{IN_W{1'b0}}, div_quo_ff[QUO_W]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= div_valid_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_prod_ff   <= mul_prod_in;
         mul_quo_ff    <= div_quo_ff[QUO_W];
         mul_y1_ff     <= div_y1_ff[QUO_W];
         mul_neg_ff    <= div_neg_ff[QUO_W];
         mul_status_ff <= div_status_ff[QUO_W];
      end
   end

   // ---------------- intercept and output register ----------------
   status_type         rsp_status_ff;
   logic               rsp_written_ff;
   logic [SLOPE_W-1:0] rsp_slope_ff;
   logic [ICPT_W-1:0]  rsp_icpt_ff;

   logic [SLOPE_W-1:0] slope_mag;
   logic [ICPT_W-1:0]  icpt_base;
   logic [ICPT_W-1:0]  icpt_prod;
   logic               written_in;
   logic [SLOPE_W-1:0] slope_in;
   logic [ICPT_W-1:0]  icpt_in;

   always_comb begin
      slope_mag  = SLOPE_W'(mul_quo_ff);
      icpt_base  = ICPT_W'({mul_y1_ff, {FRAC_BITS{1'b0}}});
      icpt_prod  = ICPT_W'(mul_prod_ff);
      written_in = mul_status_ff != STATUS_DIV_ZERO;
      // Negative slope: y1 - x1*(-q) = y1 + x1*q.
      if (!written_in) begin
         slope_in = '0;
         icpt_in  = '0;
      end else if (mul_neg_ff) begin
         slope_in = -slope_mag;
         icpt_in  = icpt_base + icpt_prod;
      end else begin
         slope_in = slope_mag;
         icpt_in  = icpt_base - icpt_prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff  <= mul_status_ff;
         rsp_written_ff <= written_in;
         rsp_slope_ff   <= slope_in;
         rsp_icpt_ff    <= icpt_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - 3 - SLOPE_W - ICPT_W){1'b0}}, rsp_icpt_ff, rsp_slope_ff,
                        rsp_written_ff, rsp_status_ff};

   // ---------------- assertions ----------------
`include "two_point_calibration_fit_macros.svh"

   `TPCF_ASSERT_IMPLY(a_written_matches_status, rsp_valid_ff,
      rsp_written_ff == (rsp_status_ff != STATUS_DIV_ZERO), "fit_written disagrees with status")
   `TPCF_ASSERT_IMPLY(a_div_zero_clears_fit, rsp_valid_ff && !rsp_written_ff,
      rsp_slope_ff == '0 && rsp_icpt_ff == '0, "fit not cleared on divide by zero")
   `TPCF_ASSERT_IMPLY(a_ok_slope_nonneg, rsp_valid_ff && rsp_status_ff == STATUS_OK,
      !rsp_slope_ff[SLOPE_W-1], "negative slope on ordered points")
   `TPCF_ASSERT_NEXT(a_max_ref_write, csr_valid && csr_index == REG_MAX_REFERENCE,
      max_ref_ff == $past(csr_data), "max_reference write lost")

endmodule
